// ----- rtl/core/nearest_palette_color_top_assert.svh -----
// Assertion macros for the nearest palette color block.
// Included by nearest_palette_color_top; needs no other file.
`ifndef NEAREST_PALETTE_COLOR_TOP_ASSERT_SVH
`define NEAREST_PALETTE_COLOR_TOP_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted
`define NPC_ASSERT_IMPLIES(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted
`define NPC_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/core/npc_pkg.sv -----
// Shared types, constants and helpers for the nearest palette color block.
// No dependencies; used by every module in rtl/core.
`timescale 1ns / 1ps

package npc_pkg;

    // Default configuration of the block
    localparam int PALETTE_SIZE_DEF = 8;
    localparam int CHANNEL_BITS_DEF = 8;

    // Fixed widths of the ports
    localparam int PIX_BITS        = 8;
    localparam int SKIP_BITS       = 4;
    localparam int INDEX_BITS      = 3;
    localparam int NUM_COLORS_BITS = 4;
    localparam int CFG_IDX_BITS    = 3;
    localparam int CFG_DATA_BITS   = 48;
    // Register data is treated as a 64-bit word when unpacking entries
    localparam int CFG_EXT_BITS    = 64;
    localparam int NUM_PAIR_REGS   = 4;

    localparam logic [NUM_COLORS_BITS-1:0] NUM_COLORS_RESET = NUM_COLORS_BITS'(8);

    // Configuration register indexes
    typedef enum logic [CFG_IDX_BITS-1:0] {
        REG_NUM_COLORS = 3'd0,
        REG_PAIR_0     = 3'd1,
        REG_PAIR_1     = 3'd2,
        REG_PAIR_2     = 3'd3,
        REG_PAIR_3     = 3'd4
    } cfg_reg_e;

    // One input beat
    typedef struct packed {
        logic [PIX_BITS-1:0]         in_red;
        logic [PIX_BITS-1:0]         in_green;
        logic [PIX_BITS-1:0]         in_blue;
        logic                        allow_gray;
        logic signed [SKIP_BITS-1:0] skip_entry;
    } pixel_t;

    // One result beat
    typedef struct packed {
        logic [INDEX_BITS-1:0] entry_index;
        logic                  found;
        logic [PIX_BITS-1:0]   out_red;
        logic [PIX_BITS-1:0]   out_green;
        logic [PIX_BITS-1:0]   out_blue;
    } result_t;

    // Width of one absolute channel difference
    function automatic int diff_bits(int cb);
        return (cb > PIX_BITS) ? cb : PIX_BITS;
    endfunction

    // Width of a squared distance: three squares summed
    function automatic int dist_bits(int cb);
        return 2 * diff_bits(cb) + 2;
    endfunction

endpackage

// ----- rtl/core/npc_cfg.sv -----
// Configuration registers: entry count and palette entries.
// Depends on npc_pkg.
`timescale 1ns / 1ps

module npc_cfg #(
    parameter int PALETTE_SIZE = npc_pkg::PALETTE_SIZE_DEF,
    parameter int CHANNEL_BITS = npc_pkg::CHANNEL_BITS_DEF
) (
    input  logic                                     clk,
    input  logic                                     rst_n,
    input  logic                                     cfg_we,
    input  logic [npc_pkg::CFG_IDX_BITS-1:0]         cfg_index,
    input  logic [npc_pkg::CFG_DATA_BITS-1:0]        cfg_data,
    output logic [PALETTE_SIZE-1:0][3*CHANNEL_BITS-1:0] palette,
    output logic [$clog2(PALETTE_SIZE+1)-1:0]        num_used
);

    localparam int ENTRY_BITS = 3 * CHANNEL_BITS;
    localparam int NUM_W      = $clog2(PALETTE_SIZE + 1);

    logic [npc_pkg::NUM_COLORS_BITS-1:0] num_colors_reg;
    logic [npc_pkg::NUM_COLORS_BITS-1:0] num_colors_next;
    logic [npc_pkg::CFG_EXT_BITS-1:0]    data_ext;

    assign data_ext = npc_pkg::CFG_EXT_BITS'(cfg_data);

    // Entry count register
    always_comb
    begin
        num_colors_next = num_colors_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                npc_pkg::REG_NUM_COLORS: num_colors_next = cfg_data[npc_pkg::NUM_COLORS_BITS-1:0];
                default:                 num_colors_next = num_colors_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            num_colors_reg <= npc_pkg::NUM_COLORS_RESET;
        else
            num_colors_reg <= num_colors_next;
    end

    // Counts above the palette size saturate
    assign num_used = (int'(num_colors_reg) > PALETTE_SIZE) ? NUM_W'(PALETTE_SIZE)
                                                            : NUM_W'(num_colors_reg);

    // Palette entries; two entries per pair register
    for (genvar e = 0; e < PALETTE_SIZE; e++)
    begin : g_entry
        localparam int PAIR = e / 2;
        if (PAIR < npc_pkg::NUM_PAIR_REGS)
        begin : g_loadable
            logic [ENTRY_BITS-1:0] entry_reg;
            logic [ENTRY_BITS-1:0] entry_next;
            logic [ENTRY_BITS-1:0] entry_wdata;
            logic                  hit;

            // Unpack R, G, B; bits past the data word read as zero
            for (genvar k = 0; k < 3; k++)
            begin : g_chan
                localparam int SH = (e % 2) * ENTRY_BITS + k * CHANNEL_BITS;
                assign entry_wdata[k*CHANNEL_BITS +: CHANNEL_BITS] =
                    CHANNEL_BITS'(data_ext >> SH);
            end

            assign hit = cfg_we &&
                         (int'(cfg_index) == int'(npc_pkg::REG_PAIR_0) + PAIR);
            assign entry_next = hit ? entry_wdata : entry_reg;

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                    entry_reg <= '0;
                else
                    entry_reg <= entry_next;
            end

            assign palette[e] = entry_reg;
        end
        else
        begin : g_fixed
            // No register reaches these entries: they stay black
            assign palette[e] = '0;
        end
    end

endmodule

// ----- rtl/core/npc_dist.sv -----
// Distance stage: per-entry qualification and squared RGB distance, registered.
// Depends on npc_pkg.
`timescale 1ns / 1ps

module npc_dist #(
    parameter int PALETTE_SIZE = npc_pkg::PALETTE_SIZE_DEF,
    parameter int CHANNEL_BITS = npc_pkg::CHANNEL_BITS_DEF
) (
    input  logic                                        clk,
    input  logic                                        rst_n,
    input  logic                                        vld_in,
    input  npc_pkg::pixel_t                             pix,
    input  logic [PALETTE_SIZE-1:0][3*CHANNEL_BITS-1:0] palette,
    input  logic [$clog2(PALETTE_SIZE+1)-1:0]           num_used,
    output logic                                        vld_out,
    output logic [PALETTE_SIZE-1:0]                     qual,
    output logic [PALETTE_SIZE-1:0][npc_pkg::dist_bits(CHANNEL_BITS)-1:0] err
);

    localparam int DW = npc_pkg::diff_bits(CHANNEL_BITS);
    localparam int EW = npc_pkg::dist_bits(CHANNEL_BITS);

    logic [2:0][npc_pkg::PIX_BITS-1:0] pix_ch;
    logic                              skip_on;
    logic                              vld_reg;
    logic [PALETTE_SIZE-1:0]           qual_reg;
    logic [PALETTE_SIZE-1:0]           qual_next;
    logic [PALETTE_SIZE-1:0][EW-1:0]   err_reg;
    logic [PALETTE_SIZE-1:0][EW-1:0]   err_next;

    assign pix_ch[0] = pix.in_red;
    assign pix_ch[1] = pix.in_green;
    assign pix_ch[2] = pix.in_blue;
    // A negative skip index excludes nothing
    assign skip_on   = !pix.skip_entry[npc_pkg::SKIP_BITS-1];

    for (genvar i = 0; i < PALETTE_SIZE; i++)
    begin : g_ent
        logic [2:0][DW-1:0]   diff;
        logic [2:0][2*DW-1:0] sq;
        logic                 is_gray;
        logic                 skipped;

        // Absolute difference and square per channel
        for (genvar k = 0; k < 3; k++)
        begin : g_ch
            logic [DW-1:0] a;
            logic [DW-1:0] b;
            assign a       = DW'(palette[i][k*CHANNEL_BITS +: CHANNEL_BITS]);
            assign b       = DW'(pix_ch[k]);
            assign diff[k] = (a > b) ? (a - b) : (b - a);
            assign sq[k]   = diff[k] * diff[k];
        end

        assign is_gray = (palette[i][0 +: CHANNEL_BITS] ==
                          palette[i][CHANNEL_BITS +: CHANNEL_BITS]) &&
                         (palette[i][0 +: CHANNEL_BITS] ==
                          palette[i][2*CHANNEL_BITS +: CHANNEL_BITS]);
        assign skipped = skip_on &&
                         (int'(pix.skip_entry[npc_pkg::SKIP_BITS-2:0]) == i);

        assign qual_next[i] = (int'(num_used) > i) && (pix.allow_gray || !is_gray) &&
                              !skipped;
        assign err_next[i]  = EW'(sq[0]) + EW'(sq[1]) + EW'(sq[2]);
    end

    // Stage valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= 1'b0;
        else
            vld_reg <= vld_in;
    end

    // Stage payload
    always_ff @(posedge clk)
    begin
        if (vld_in)
        begin
            qual_reg <= qual_next;
            err_reg  <= err_next;
        end
    end

    assign vld_out = vld_reg;
    assign qual    = qual_reg;
    assign err     = err_reg;

endmodule

// ----- rtl/core/npc_select.sv -----
// Select stage: minimum tree over qualified entries, color lookup, result register.
// Depends on npc_pkg.
`timescale 1ns / 1ps

module npc_select #(
    parameter int PALETTE_SIZE = npc_pkg::PALETTE_SIZE_DEF,
    parameter int CHANNEL_BITS = npc_pkg::CHANNEL_BITS_DEF
) (
    input  logic                                        clk,
    input  logic                                        rst_n,
    input  logic                                        vld_in,
    input  logic [PALETTE_SIZE-1:0]                     qual,
    input  logic [PALETTE_SIZE-1:0][npc_pkg::dist_bits(CHANNEL_BITS)-1:0] err,
    input  logic [PALETTE_SIZE-1:0][3*CHANNEL_BITS-1:0] palette,
    output logic                                        done,
    output npc_pkg::result_t                            result
);

    localparam int EW     = npc_pkg::dist_bits(CHANNEL_BITS);
    localparam int IW     = (PALETTE_SIZE > 1) ? $clog2(PALETTE_SIZE) : 1;
    localparam int LEAVES = 2 ** IW;
    localparam int NODES  = 2 * LEAVES - 1;

    logic [NODES-1:0]          node_vld;
    logic [NODES-1:0][EW-1:0]  node_err;
    logic [NODES-1:0][IW-1:0]  node_idx;

    logic                      found;
    logic [IW-1:0]             best;
    logic [3*CHANNEL_BITS-1:0] best_color;
    npc_pkg::result_t          result_next;
    npc_pkg::result_t          result_reg;
    logic                      done_reg;

    // Leaves in index order; padding leaves never qualify
    for (genvar i = 0; i < LEAVES; i++)
    begin : g_leaf
        if (i < PALETTE_SIZE)
        begin : g_real
            assign node_vld[LEAVES-1+i] = qual[i];
            assign node_err[LEAVES-1+i] = err[i];
            assign node_idx[LEAVES-1+i] = IW'(i);
        end
        else
        begin : g_pad
            assign node_vld[LEAVES-1+i] = 1'b0;
            assign node_err[LEAVES-1+i] = '0;
            assign node_idx[LEAVES-1+i] = '0;
        end
    end

    // Inner nodes: left child holds lower indices, so it wins ties
    for (genvar n = 0; n < LEAVES - 1; n++)
    begin : g_node
        logic take_left;
        assign take_left   = node_vld[2*n+1] &&
                             (!node_vld[2*n+2] || (node_err[2*n+1] <= node_err[2*n+2]));
        assign node_vld[n] = node_vld[2*n+1] || node_vld[2*n+2];
        assign node_err[n] = take_left ? node_err[2*n+1] : node_err[2*n+2];
        assign node_idx[n] = take_left ? node_idx[2*n+1] : node_idx[2*n+2];
    end

    assign found      = node_vld[0];
    assign best       = found ? node_idx[0] : '0;
    assign best_color = found ? palette[best] : '0;

    // Result beat; channels narrowed or widened to the port width
    always_comb
    begin
        result_next.entry_index = npc_pkg::INDEX_BITS'(best);
        result_next.found       = found;
        result_next.out_red     = npc_pkg::PIX_BITS'(best_color[0 +: CHANNEL_BITS]);
        result_next.out_green   = npc_pkg::PIX_BITS'(best_color[CHANNEL_BITS +: CHANNEL_BITS]);
        result_next.out_blue    = npc_pkg::PIX_BITS'(best_color[2*CHANNEL_BITS +: CHANNEL_BITS]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= vld_in;
    end

    always_ff @(posedge clk)
    begin
        if (vld_in)
            result_reg <= result_next;
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

// ----- rtl/core/nearest_palette_color_top.sv -----
// Top level of the nearest palette color block.
// Depends on npc_pkg, npc_cfg, npc_dist, npc_select and nearest_palette_color_top_assert.svh.
//
//   channel   direction  handshake              payload
//   input     in         start / busy           pixel  (npc_pkg::pixel_t)
//   result    out        done (one-cycle beat)  result (npc_pkg::result_t)
//   config    in         cfg_valid / cfg_ready  cfg_index, cfg_data
//
// One pixel beat is taken every cycle; busy stays low and cfg_ready stays high.
// The pipeline has three registers: input register, distance register, result register.
// The distance stage (three squares per entry) and the minimum tree set the clock.
// Reset clears the pipeline valids, sets the entry count to 8 and the palette to black.
// The receiver cannot stall: done marks each result for exactly one cycle.
`timescale 1ns / 1ps
`include "nearest_palette_color_top_assert.svh"

module nearest_palette_color_top #(
    parameter int PALETTE_SIZE = npc_pkg::PALETTE_SIZE_DEF,
    parameter int CHANNEL_BITS = npc_pkg::CHANNEL_BITS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    output logic                              busy,
    input  npc_pkg::pixel_t                   pixel,
    output logic                              done,
    output npc_pkg::result_t                  result,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [npc_pkg::CFG_IDX_BITS-1:0]  cfg_index,
    input  logic [npc_pkg::CFG_DATA_BITS-1:0] cfg_data
);

    localparam int EW = npc_pkg::dist_bits(CHANNEL_BITS);

    logic                                        accept;
    logic                                        in_vld_reg;
    npc_pkg::pixel_t                             pix_reg;
    logic [PALETTE_SIZE-1:0][3*CHANNEL_BITS-1:0] palette;
    logic [$clog2(PALETTE_SIZE+1)-1:0]           num_used;
    logic                                        dist_vld;
    logic [PALETTE_SIZE-1:0]                     dist_qual;
    logic [PALETTE_SIZE-1:0][EW-1:0]             dist_err;

    // Handshakes: the pipeline never holds off either side
    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;
    assign accept    = start && !busy;

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_vld_reg <= 1'b0;
        else
            in_vld_reg <= accept;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            pix_reg <= pixel;
    end

    npc_cfg #(
        .PALETTE_SIZE (PALETTE_SIZE),
        .CHANNEL_BITS (CHANNEL_BITS)
    ) u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .palette   (palette),
        .num_used  (num_used)
    );

    npc_dist #(
        .PALETTE_SIZE (PALETTE_SIZE),
        .CHANNEL_BITS (CHANNEL_BITS)
    ) u_dist (
        .clk      (clk),
        .rst_n    (rst_n),
        .vld_in   (in_vld_reg),
        .pix      (pix_reg),
        .palette  (palette),
        .num_used (num_used),
        .vld_out  (dist_vld),
        .qual     (dist_qual),
        .err      (dist_err)
    );

    npc_select #(
        .PALETTE_SIZE (PALETTE_SIZE),
        .CHANNEL_BITS (CHANNEL_BITS)
    ) u_select (
        .clk     (clk),
        .rst_n   (rst_n),
        .vld_in  (dist_vld),
        .qual    (dist_qual),
        .err     (dist_err),
        .palette (palette),
        .done    (done),
        .result  (result)
    );

    // Checks
    `NPC_ASSERT_NEXT(a_accept_gives_done, clk, rst_n, accept, ##2 done,
        "accepted beat did not produce a result three cycles later")
    `NPC_ASSERT_IMPLIES(a_done_has_source, clk, rst_n, done, $past(accept, 3),
        "result beat without an accepted input three cycles earlier")
    `NPC_ASSERT_IMPLIES(a_index_in_use, clk, rst_n, done && result.found,
        int'(result.entry_index) < int'(num_used),
        "chosen entry lies beyond the entries in use")
    `NPC_ASSERT_IMPLIES(a_none_is_zero, clk, rst_n, done && !result.found,
        result.entry_index == '0 && result.out_red == '0 && result.out_green == '0 && result.out_blue == '0,
        "empty result carries nonzero fields")

endmodule

// ----- dv/tb.sv -----
// Self-checking testbench for nearest_palette_color_top: palette search per pixel beat.
// Depends on npc_pkg and the block's RTL; predicts every result and checks it in order.
`timescale 1ns / 1ps

module tb;

    localparam int PALETTE_ENTRIES  = npc_pkg::PALETTE_SIZE_DEF;
    localparam int PIPE_LATENCY     = 3;
    localparam int FIRST_UNUSED_REG = npc_pkg::NUM_PAIR_REGS + 1;
    localparam int LAST_REG_INDEX   = (1 << npc_pkg::CFG_IDX_BITS) - 1;
    localparam int MAX_REPORTS      = 10;
    localparam int CYCLE_LIMIT      = 200000;
    localparam int RANDOM_BLOCKS    = 11;
    localparam int PIXELS_PER_BLOCK = 60;
    localparam int NO_SKIP          = -1;

    logic                              clk;
    logic                              rst_n;
    logic                              start;
    logic                              busy;
    npc_pkg::pixel_t                   pixel;
    logic                              done;
    npc_pkg::result_t                  result;
    logic                              cfg_valid;
    logic                              cfg_ready;
    logic [npc_pkg::CFG_IDX_BITS-1:0]  cfg_index;
    logic [npc_pkg::CFG_DATA_BITS-1:0] cfg_data;

    // Shadow of the block's registers
    logic [npc_pkg::NUM_COLORS_BITS-1:0] shadow_num_colors;
    logic [npc_pkg::PIX_BITS-1:0]        shadow_red   [PALETTE_ENTRIES];
    logic [npc_pkg::PIX_BITS-1:0]        shadow_green [PALETTE_ENTRIES];
    logic [npc_pkg::PIX_BITS-1:0]        shadow_blue  [PALETTE_ENTRIES];

    // Palette under construction, packed {B, G, R}
    logic [3*npc_pkg::PIX_BITS-1:0] palette_build [PALETTE_ENTRIES];

    npc_pkg::result_t pending_matches [$];
    int               failures;
    int               cycle_count;
    int               sender_idle_pct;

    nearest_palette_color_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .pixel     (pixel),
        .done      (done),
        .result    (result),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #6 clk = ~clk;

    // Nearest qualifying entry under the shadow registers
    function automatic npc_pkg::result_t predict_nearest(npc_pkg::pixel_t p);
        npc_pkg::result_t r;
        int               limit;
        int               skip;
        int               best;
        int               best_err;
        int               sq_err;
        int               dr;
        int               dg;
        int               db;
        bit               have;
        bit               is_gray;
        r        = '0;
        have     = 1'b0;
        best     = 0;
        best_err = 0;
        skip     = $signed(p.skip_entry);
        limit    = (shadow_num_colors > PALETTE_ENTRIES) ? PALETTE_ENTRIES
                                                         : int'(shadow_num_colors);
        for (int i = 0; i < limit; i++)
        begin
            is_gray = (shadow_red[i] == shadow_green[i]) && (shadow_red[i] == shadow_blue[i]);
            if ((p.allow_gray || !is_gray) && (skip != i))
            begin
                dr     = int'(shadow_red[i]) - int'(p.in_red);
                dg     = int'(shadow_green[i]) - int'(p.in_green);
                db     = int'(shadow_blue[i]) - int'(p.in_blue);
                sq_err = dr * dr + dg * dg + db * db;
                if (!have || sq_err < best_err)
                begin
                    have     = 1'b1;
                    best_err = sq_err;
                    best     = i;
                end
            end
        end
        if (have)
        begin
            r.entry_index = npc_pkg::INDEX_BITS'(best);
            r.found       = 1'b1;
            r.out_red     = shadow_red[best];
            r.out_green   = shadow_green[best];
            r.out_blue    = shadow_blue[best];
        end
        return r;
    endfunction

    // Register write as the block sees it
    function automatic void apply_cfg_write(logic [npc_pkg::CFG_IDX_BITS-1:0] idx,
                                            logic [npc_pkg::CFG_DATA_BITS-1:0] data);
        int pair;
        pair = int'(idx) - int'(npc_pkg::REG_PAIR_0);
        case (npc_pkg::cfg_reg_e'(idx))
            npc_pkg::REG_NUM_COLORS:
                shadow_num_colors = data[npc_pkg::NUM_COLORS_BITS-1:0];
            npc_pkg::REG_PAIR_0, npc_pkg::REG_PAIR_1, npc_pkg::REG_PAIR_2, npc_pkg::REG_PAIR_3:
            begin
                for (int h = 0; h < 2; h++)
                begin
                    shadow_red[2*pair+h]   = data[24*h +: 8];
                    shadow_green[2*pair+h] = data[24*h+8 +: 8];
                    shadow_blue[2*pair+h]  = data[24*h+16 +: 8];
                end
            end
            default:
                ;
        endcase
    endfunction

    function automatic npc_pkg::pixel_t make_pixel(int r, int g, int b, bit gray, int skip);
        npc_pkg::pixel_t p;
        p.in_red     = npc_pkg::PIX_BITS'(r);
        p.in_green   = npc_pkg::PIX_BITS'(g);
        p.in_blue    = npc_pkg::PIX_BITS'(b);
        p.allow_gray = gray;
        p.skip_entry = npc_pkg::SKIP_BITS'(skip);
        return p;
    endfunction

    // Send one pixel beat, idling at random first
    task automatic send_pixel(npc_pkg::pixel_t p);
        while ($urandom_range(99) < sender_idle_pct)
        begin
            @(negedge clk);
            start <= 1'b0;
        end
        @(negedge clk);
        start <= 1'b1;
        pixel <= p;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        pending_matches.insert(pending_matches.size(), predict_nearest(p));
    endtask

    // Stop sending and let every result come out
    task automatic drain_pipeline();
        @(negedge clk);
        start <= 1'b0;
        while (pending_matches.size() != 0)
            @(negedge clk);
        repeat (PIPE_LATENCY + 1) @(negedge clk);
    endtask

    task automatic write_reg(logic [npc_pkg::CFG_IDX_BITS-1:0] idx,
                             logic [npc_pkg::CFG_DATA_BITS-1:0] data);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        apply_cfg_write(idx, data);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic program_palette();
        for (int p = 0; p < npc_pkg::NUM_PAIR_REGS; p++)
            write_reg(npc_pkg::CFG_IDX_BITS'(int'(npc_pkg::REG_PAIR_0) + p),
                      npc_pkg::CFG_DATA_BITS'({palette_build[2*p+1], palette_build[2*p]}));
    endtask

    // Reset palette is all black with eight entries in use
    task automatic test_reset_palette();
        send_pixel(make_pixel(255, 255, 255, 1'b1, NO_SKIP));
        send_pixel(make_pixel(0, 0, 0, 1'b0, NO_SKIP));
        send_pixel(make_pixel(17, 200, 3, 1'b1, 0));
        drain_pipeline();
    endtask

    // Gray entries, duplicate entries (tie), skip values incl. negative
    task automatic test_gray_and_skip();
        palette_build[0] = 24'h0A0A0A;
        palette_build[1] = 24'h0000FF;
        palette_build[2] = 24'h0000FF;
        palette_build[3] = 24'h00FF00;
        palette_build[4] = 24'hFF0000;
        palette_build[5] = 24'hFFFFFF;
        palette_build[6] = 24'h204080;
        palette_build[7] = 24'h000000;
        write_reg(npc_pkg::REG_NUM_COLORS, npc_pkg::CFG_DATA_BITS'(PALETTE_ENTRIES));
        program_palette();
        send_pixel(make_pixel(255, 0, 0, 1'b0, NO_SKIP));
        send_pixel(make_pixel(255, 0, 0, 1'b0, 1));
        send_pixel(make_pixel(255, 255, 255, 1'b1, NO_SKIP));
        send_pixel(make_pixel(255, 255, 255, 1'b0, NO_SKIP));
        send_pixel(make_pixel(0, 0, 0, 1'b1, NO_SKIP));
        send_pixel(make_pixel(0, 0, 0, 1'b1, 7));
        send_pixel(make_pixel(0, 0, 0, 1'b1, -8));
        send_pixel(make_pixel(128, 64, 32, 1'b0, 6));
        send_pixel(make_pixel(12, 10, 9, 1'b1, NO_SKIP));
        drain_pipeline();
    endtask

    // Entry count at zero, one, inside, and above the palette size
    task automatic test_entry_count();
        write_reg(npc_pkg::REG_NUM_COLORS, '0);
        send_pixel(make_pixel(255, 0, 0, 1'b1, NO_SKIP));
        drain_pipeline();
        write_reg(npc_pkg::REG_NUM_COLORS, npc_pkg::CFG_DATA_BITS'(1));
        send_pixel(make_pixel(10, 10, 10, 1'b1, 0));
        send_pixel(make_pixel(10, 10, 10, 1'b0, NO_SKIP));
        drain_pipeline();
        write_reg(npc_pkg::REG_NUM_COLORS, npc_pkg::CFG_DATA_BITS'(3));
        send_pixel(make_pixel(0, 255, 0, 1'b0, 5));
        drain_pipeline();
        write_reg(npc_pkg::REG_NUM_COLORS, npc_pkg::CFG_DATA_BITS'(9));
        send_pixel(make_pixel(1, 1, 1, 1'b1, NO_SKIP));
        drain_pipeline();
        write_reg(npc_pkg::REG_NUM_COLORS, {npc_pkg::CFG_DATA_BITS{1'b1}});
        send_pixel(make_pixel(250, 250, 250, 1'b0, 4));
        drain_pipeline();
    endtask

    // Writes to indexes past the last pair register change nothing
    task automatic test_unused_registers();
        for (int idx = FIRST_UNUSED_REG; idx <= LAST_REG_INDEX; idx++)
            write_reg(npc_pkg::CFG_IDX_BITS'(idx), {npc_pkg::CFG_DATA_BITS{1'b1}});
        send_pixel(make_pixel(30, 60, 90, 1'b1, NO_SKIP));
        drain_pipeline();
    endtask

    function automatic logic [npc_pkg::PIX_BITS-1:0] near_channel(
        logic [npc_pkg::PIX_BITS-1:0] c);
        int v;
        v = int'(c) + int'($urandom_range(6)) - 3;
        if (v < 0)
            v = 0;
        if (v > 255)
            v = 255;
        return npc_pkg::PIX_BITS'(v);
    endfunction

    // Random palettes and pixels; sender idles at the given rate
    task automatic test_random_traffic(int idle_pct);
        logic [npc_pkg::PIX_BITS-1:0]   v;
        logic [3*npc_pkg::PIX_BITS-1:0] e;
        npc_pkg::pixel_t                p;
        int                             j;
        sender_idle_pct = idle_pct;
        for (int blk = 0; blk < RANDOM_BLOCKS; blk++)
        begin
            for (int i = 0; i < PALETTE_ENTRIES; i++)
            begin
                v = npc_pkg::PIX_BITS'($urandom);
                case ($urandom_range(3))
                    0: palette_build[i] = 24'($urandom);
                    1: palette_build[i] = {v, v, v};
                    2: palette_build[i] = (i > 0) ? palette_build[i-1] : 24'($urandom);
                    default:
                        for (int k = 0; k < 3; k++)
                            palette_build[i][8*k +: 8] = $urandom_range(1) ? 8'hFF : 8'h00;
                endcase
            end
            if ($urandom_range(9) < 8)
                write_reg(npc_pkg::REG_NUM_COLORS,
                          npc_pkg::CFG_DATA_BITS'($urandom_range(PALETTE_ENTRIES, 1)));
            else
                write_reg(npc_pkg::REG_NUM_COLORS,
                          npc_pkg::CFG_DATA_BITS'({$urandom, $urandom}));
            program_palette();
            if ($urandom_range(3) == 0)
                write_reg(npc_pkg::CFG_IDX_BITS'($urandom_range(LAST_REG_INDEX,
                                                                 FIRST_UNUSED_REG)),
                          npc_pkg::CFG_DATA_BITS'({$urandom, $urandom}));
            for (int n = 0; n < PIXELS_PER_BLOCK; n++)
            begin
                p.allow_gray = 1'($urandom_range(1));
                p.skip_entry = npc_pkg::SKIP_BITS'($urandom);
                case ($urandom_range(2))
                    0:
                    begin
                        p.in_red   = npc_pkg::PIX_BITS'($urandom);
                        p.in_green = npc_pkg::PIX_BITS'($urandom);
                        p.in_blue  = npc_pkg::PIX_BITS'($urandom);
                    end
                    1:
                    begin
                        j          = int'($urandom_range(PALETTE_ENTRIES - 1));
                        e          = palette_build[j];
                        p.in_red   = near_channel(e[7:0]);
                        p.in_green = near_channel(e[15:8]);
                        p.in_blue  = near_channel(e[23:16]);
                    end
                    default:
                    begin
                        p.in_red   = $urandom_range(1) ? 8'hFF : 8'h00;
                        p.in_green = $urandom_range(1) ? 8'hFF : 8'h00;
                        p.in_blue  = $urandom_range(1) ? 8'hFF : 8'h00;
                    end
                endcase
                send_pixel(p);
            end
            drain_pipeline();
        end
    endtask

    // Compare each result beat with the oldest prediction
    always @(posedge clk)
    begin : check_results
        npc_pkg::result_t want;
        if (rst_n && done)
        begin
            if (pending_matches.size() == 0)
            begin
                if (failures < MAX_REPORTS)
                    $display("tb: unexpected result beat %h", result);
                failures++;
            end
            else
            begin
                want = pending_matches.pop_front();
                if (result.entry_index !== want.entry_index || result.found !== want.found ||
                    result.out_red !== want.out_red || result.out_green !== want.out_green ||
                    result.out_blue !== want.out_blue)
                begin
                    if (failures < MAX_REPORTS)
                        $display({"tb: mismatch exp idx=%0d found=%0d rgb=%h/%h/%h",
                                  " got idx=%0d found=%0d rgb=%h/%h/%h"},
                                 want.entry_index, want.found, want.out_red, want.out_green,
                                 want.out_blue, result.entry_index, result.found,
                                 result.out_red, result.out_green, result.out_blue);
                    failures++;
                end
            end
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    initial
    begin
        failures          = 0;
        cycle_count       = 0;
        sender_idle_pct   = 0;
        shadow_num_colors = npc_pkg::NUM_COLORS_RESET;
        for (int i = 0; i < PALETTE_ENTRIES; i++)
        begin
            shadow_red[i]   = '0;
            shadow_green[i] = '0;
            shadow_blue[i]  = '0;
        end
        rst_n     = 1'b0;
        start     = 1'b0;
        pixel     = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_reset_palette();
        test_gray_and_skip();
        test_entry_count();
        test_unused_registers();
        test_random_traffic(22);
        test_random_traffic(60);
        test_random_traffic(0);

        drain_pipeline();
        repeat (2 * PIPE_LATENCY) @(posedge clk);
        if (failures == 0 && pending_matches.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
